// File: rtl/su3_matrix_multiply_assert.svh
// Assertion helpers for the SU(3) matrix multiplier.
`ifndef SU3_MATRIX_MULTIPLY_ASSERT_SVH
`define SU3_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define SU3MM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SU3MM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/su3mm_pkg.sv
package su3mm_pkg;

   localparam int unsigned DATA_WIDTH_DEF = 32;
   localparam int unsigned FRAC_BITS_DEF  = 30;

   typedef logic [1:0] pos_type;
   typedef logic [3:0] elem_type;

   localparam pos_type LAST_POS = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_PAIR  = 5'b01000,
      ST_POST  = 5'b10000
   } state_type;

   // (n + 1) mod 3
   function automatic pos_type next_pos(input pos_type p);
      next_pos = (p == LAST_POS) ? 2'd0 : p + 2'd1;
   endfunction

   // row * 3 + col
   function automatic elem_type elem_index(input pos_type r, input pos_type c);
      elem_index = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
   endfunction

endpackage

// File: rtl/su3_matrix_multiply.sv
// 3x3 complex matrix product out = p * q, signed fixed point, saturating.
// Input channel: an item transfers when start is high and busy is low. It
//   writes element (req_row, req_col) of both p and q. An item with
//   req_final_load set writes its element and then starts the product.
//   Loads do not raise busy. In compressed mode row 2 is not written.
// Result channel: each product element is shown for one cycle with
//   rsp_strobe high, row by row; rsp_run_end marks the last one. The
//   receiver cannot stall, and nothing here waits on it.
// Configuration: csr_wr_en writes csr_wr_data into the compressed mode bit,
//   while the block is idle; the user must ensure this, the block does not.
//   Compressed mode keeps rows 0 and 1 and rebuilds row 2 of q as the conjugate
//   cross product; six results are produced. One real multiplier is shared
//   by all products. Each complex multiply runs through operand read, four
//   multiplies through a two-stage multiply/round pipe, pair add and accumulate
//   (in the compressed rebuild, a store of the cross-product term instead). The
//   rebuild of row 2 runs before the first result. busy is high from the final
//   load until the last result.
// Reset: synchronous; clears the sequencer and the mode bit. Matrix stores
//   are not cleared and must be loaded before use.
module su3_matrix_multiply #(
   parameter int unsigned DATA_WIDTH = su3mm_pkg::DATA_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = su3mm_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  su3mm_pkg::pos_type           req_row,
   input  su3mm_pkg::pos_type           req_col,
   input  logic signed [DATA_WIDTH-1:0] req_p_real,
   input  logic signed [DATA_WIDTH-1:0] req_p_imag,
   input  logic signed [DATA_WIDTH-1:0] req_q_real,
   input  logic signed [DATA_WIDTH-1:0] req_q_imag,
   input  logic                         req_final_load,
   output logic                         rsp_strobe,
   output su3mm_pkg::pos_type           rsp_out_row,
   output su3mm_pkg::pos_type           rsp_out_col,
   output logic signed [DATA_WIDTH-1:0] rsp_prod_real,
   output logic signed [DATA_WIDTH-1:0] rsp_prod_imag,
   output logic                         rsp_run_end,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data
);
   import su3mm_pkg::*;
   `include "su3_matrix_multiply_assert.svh"

   localparam int unsigned DW = DATA_WIDTH;
   localparam int unsigned PW = 2 * DATA_WIDTH;

   localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [PW:0] RND_POS = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [PW:0] RND_NEG =
      ({{PW{1'b0}}, 1'b1} << FRAC_BITS) - RND_POS - {{PW{1'b0}}, 1'b1};

   function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) sat_add = s[DW] ? VMIN : VMAX;
      else sat_add = s[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} - {b[DW-1], b};
      if (s[DW] != s[DW-1]) sat_sub = s[DW] ? VMIN : VMAX;
      else sat_sub = s[DW-1:0];
   endfunction

   // round half away from zero to FRAC_BITS, then saturate
   function automatic logic signed [DW-1:0] round_sat(input logic signed [PW-1:0] p);
      logic signed [PW:0] e;
      logic signed [PW:0] sh;
      e  = {p[PW-1], p} + (p[PW-1] ? RND_NEG : RND_POS);
      sh = e >>> FRAC_BITS;
      if (sh[PW:DW-1] == {(PW-DW+2){sh[PW]}}) round_sat = sh[DW-1:0];
      else round_sat = sh[PW] ? VMIN : VMAX;
   endfunction

   // element stores, entry = {imag, real}
   logic [PW-1:0] left_mem  [9];
   logic [PW-1:0] right_mem [9];
   logic [PW-1:0] left_rd_ff, ra_rd_ff, rb_rd_ff;

   state_type state_ff, state_in;
   logic [2:0] mcnt_ff, mcnt_in;
   logic       rbld_ff, rbld_in;
   logic       rs_ff, rs_in;
   pos_type    rk_ff, rk_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic       comp_ff, comp_in;
   logic       pval_ff, pval_in;
   logic [1:0] ptag_ff, ptag_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [DW-1:0] m_ff [4];
   logic signed [DW-1:0] rnd_in;
   logic signed [DW-1:0] t_re_ff, t_re_in, t_im_ff, t_im_in;
   logic signed [DW-1:0] f_re_ff, f_re_in, f_im_ff, f_im_in;
   logic signed [DW-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [DW-1:0] rq_re_ff [3];
   logic signed [DW-1:0] rq_im_ff [3];
   logic signed [DW-1:0] rq_re_in, rq_im_in;
   logic                 strobe_ff, strobe_in;
   pos_type              out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic signed [DW-1:0] prod_real_ff, prod_real_in, prod_imag_ff, prod_imag_in;
   logic                 run_end_ff, run_end_in;

   logic                 accept, wr_en, post_dot, post_rbld;
   elem_type             wr_addr, left_addr, ra_addr, rb_addr;
   pos_type              rk1, rk2, last_row;
   logic [PW-1:0]        opa, opb;
   logic signed [DW-1:0] mul_x, mul_y, acc_new_re, acc_new_im;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign wr_en     = accept && (req_row <= LAST_POS) && (req_col <= LAST_POS)
                      && !(comp_ff && (req_row == LAST_POS));
   assign wr_addr   = elem_index(req_row, req_col);
   assign last_row  = comp_ff ? 2'd1 : LAST_POS;
   assign post_dot  = (state_ff == ST_POST) && !rbld_ff;
   assign post_rbld = (state_ff == ST_POST) && rbld_ff;

   // rebuild: f = q0[k1]*q1[k2], s = q0[k2]*q1[k1]
   assign rk1       = next_pos(rk_ff);
   assign rk2       = next_pos(rk1);
   assign left_addr = elem_index(i_ff, j_ff);
   assign ra_addr   = elem_index(2'd0, rs_ff ? rk2 : rk1);
   assign rb_addr   = rbld_ff ? elem_index(2'd1, rs_ff ? rk1 : rk2) : elem_index(j_ff, k_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= {req_p_imag, req_p_real};
         right_mem[wr_addr] <= {req_q_imag, req_q_real};
      end
      left_rd_ff <= left_mem[left_addr];
      ra_rd_ff   <= right_mem[ra_addr];
      rb_rd_ff   <= right_mem[rb_addr];
   end

   assign opa = rbld_ff ? ra_rd_ff : left_rd_ff;
   assign opb = (!rbld_ff && comp_ff && (j_ff == LAST_POS)) ?
                {rq_im_ff[k_ff], rq_re_ff[k_ff]} : rb_rd_ff;

   // real products in order: ar*br, ai*bi, ai*br, ar*bi
   always_comb begin
      case (mcnt_ff[1:0])
         2'd0: begin mul_x = opa[DW-1:0];  mul_y = opb[DW-1:0];  end
         2'd1: begin mul_x = opa[PW-1:DW]; mul_y = opb[PW-1:DW]; end
         2'd2: begin mul_x = opa[PW-1:DW]; mul_y = opb[DW-1:0];  end
         default: begin mul_x = opa[DW-1:0]; mul_y = opb[PW-1:DW]; end
      endcase
   end

   assign prod_in = mul_x * mul_y;
   assign pval_in = (state_ff == ST_MUL) && !mcnt_ff[2];
   assign ptag_in = mcnt_ff[1:0];
   assign rnd_in  = round_sat(prod_ff);
   assign t_re_in = sat_sub(m_ff[0], m_ff[1]);
   assign t_im_in = sat_add(m_ff[2], m_ff[3]);

   assign acc_new_re = (j_ff == 2'd0) ? t_re_ff : sat_add(acc_re_ff, t_re_ff);
   assign acc_new_im = (j_ff == 2'd0) ? t_im_ff : sat_add(acc_im_ff, t_im_ff);
   assign acc_re_in  = post_dot ? acc_new_re : acc_re_ff;
   assign acc_im_in  = post_dot ? acc_new_im : acc_im_ff;
   assign f_re_in    = (post_rbld && !rs_ff) ? t_re_ff : f_re_ff;
   assign f_im_in    = (post_rbld && !rs_ff) ? t_im_ff : f_im_ff;
   assign rq_re_in   = sat_sub(f_re_ff, t_re_ff);
   assign rq_im_in   = sat_sub({DW{1'b0}}, sat_sub(f_im_ff, t_im_ff));

   assign strobe_in    = post_dot && (j_ff == LAST_POS);
   assign out_row_in   = strobe_in ? i_ff : out_row_ff;
   assign out_col_in   = strobe_in ? k_ff : out_col_ff;
   assign prod_real_in = strobe_in ? acc_new_re : prod_real_ff;
   assign prod_imag_in = strobe_in ? acc_new_im : prod_imag_ff;
   assign run_end_in   = strobe_in ? ((i_ff == last_row) && (k_ff == LAST_POS)) : run_end_ff;

   assign comp_in = csr_wr_en ? csr_wr_data : comp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      mcnt_in  = 3'd0;
      rbld_in  = rbld_ff;
      rs_in    = rs_ff;
      rk_in    = rk_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_final_load) begin
               state_in = ST_FETCH;
               rbld_in  = comp_ff;
               rs_in    = 1'b0;
               rk_in    = 2'd0;
               i_in     = 2'd0;
               j_in     = 2'd0;
               k_in     = 2'd0;
            end
         end
         ST_FETCH: state_in = ST_MUL;
         ST_MUL: begin
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) state_in = ST_PAIR;
         end
         ST_PAIR: state_in = ST_POST;
         ST_POST: begin
            state_in = ST_FETCH;
            if (rbld_ff) begin
               rs_in = !rs_ff;
               if (rs_ff) begin
                  if (rk_ff == LAST_POS) begin
                     rbld_in = 1'b0;
                     rk_in   = 2'd0;
                  end else begin
                     rk_in = rk_ff + 2'd1;
                  end
               end
            end else if (j_ff != LAST_POS) begin
               j_in = j_ff + 2'd1;
            end else begin
               j_in = 2'd0;
               if (k_ff != LAST_POS) begin
                  k_in = k_ff + 2'd1;
               end else begin
                  k_in = 2'd0;
                  if (i_ff == last_row) begin
                     i_in     = 2'd0;
                     state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mcnt_ff   <= 3'd0;
         rbld_ff   <= 1'b0;
         rs_ff     <= 1'b0;
         rk_ff     <= 2'd0;
         i_ff      <= 2'd0;
         j_ff      <= 2'd0;
         k_ff      <= 2'd0;
         comp_ff   <= 1'b0;
         pval_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mcnt_ff   <= mcnt_in;
         rbld_ff   <= rbld_in;
         rs_ff     <= rs_in;
         rk_ff     <= rk_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         comp_ff   <= comp_in;
         pval_ff   <= pval_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptag_ff      <= ptag_in;
      prod_ff      <= prod_in;
      t_re_ff      <= t_re_in;
      t_im_ff      <= t_im_in;
      f_re_ff      <= f_re_in;
      f_im_ff      <= f_im_in;
      acc_re_ff    <= acc_re_in;
      acc_im_ff    <= acc_im_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      prod_real_ff <= prod_real_in;
      prod_imag_ff <= prod_imag_in;
      run_end_ff   <= run_end_in;
      if (pval_ff) m_ff[ptag_ff] <= rnd_in;
      if (post_rbld && rs_ff) begin
         rq_re_ff[rk_ff] <= rq_re_in;
         rq_im_ff[rk_ff] <= rq_im_in;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_prod_real = prod_real_ff;
   assign rsp_prod_imag = prod_imag_ff;
   assign rsp_run_end   = run_end_ff;

   `SU3MM_ASSERT_IMPLY(a_last_idle, clock, reset, rsp_strobe && rsp_run_end, !busy,
      "block still busy after the last result")
   `SU3MM_ASSERT_IMPLY(a_last_col, clock, reset, rsp_strobe && rsp_run_end,
      rsp_out_col == LAST_POS, "run end not on the last column")
   `SU3MM_ASSERT_NEXT(a_final_busy, clock, reset, start && !busy && req_final_load, busy,
      "final load did not start the product")

endmodule
